/* hw/rtl/dst_pkg.sv */
// Shared types, codes and character functions for the sequence transform block.
`default_nettype none

package dst_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 16;
    localparam int MODE_W      = 3;
    localparam int S_TDATA_W   = 40;
    localparam int M_TUSER_W   = 2;

    localparam logic [MODE_W-1:0] MODE_COMP   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RCOMP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REV    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRANS  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_XLATE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SUBSEQ = 3'd5;

    localparam logic [CHAR_W-1:0] CHAR_X = 8'h58;

    // standard genetic code, index {first, second, third} with A=0 C=1 G=2 T/U=3
    localparam logic [8*64-1:0] STD_CODE =
        "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              has;
        logic              last;
        logic              ovf;
    } dst_res_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } dst_fifo_st_t;

    function automatic logic [CHAR_W-1:0] comp_char(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] r;
        begin
            unique case (b)
                "A": r = "T";  "a": r = "t";
                "T": r = "A";  "t": r = "a";
                "U": r = "A";  "u": r = "a";
                "G": r = "C";  "g": r = "c";
                "C": r = "G";  "c": r = "g";
                "R": r = "Y";  "r": r = "y";
                "Y": r = "R";  "y": r = "r";
                "K": r = "M";  "k": r = "m";
                "M": r = "K";  "m": r = "k";
                "B": r = "V";  "b": r = "v";
                "V": r = "B";  "v": r = "b";
                "D": r = "H";  "d": r = "h";
                "H": r = "D";  "h": r = "d";
                default: r = b;
            endcase
            return r;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] swap_tu(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] r;
        begin
            unique case (b)
                "T": r = "U";  "t": r = "u";
                "U": r = "T";  "u": r = "t";
                default: r = b;
            endcase
            return r;
        end
    endfunction

    // {valid, code}
    function automatic logic [2:0] code2(input logic [CHAR_W-1:0] b);
        logic [2:0] r;
        begin
            unique case (b)
                "A", "a":           r = 3'b100;
                "C", "c":           r = 3'b101;
                "G", "g":           r = 3'b110;
                "T", "t", "U", "u": r = 3'b111;
                default:            r = 3'b000;
            endcase
            return r;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] amino(input logic [CHAR_W-1:0] a,
                                                input logic [CHAR_W-1:0] b,
                                                input logic [CHAR_W-1:0] c);
        logic [2:0] x;
        logic [2:0] y;
        logic [2:0] z;
        logic [5:0] idx;
        logic [CHAR_W-1:0] r;
        begin
            x = code2(a);
            y = code2(b);
            z = code2(c);
            idx = {x[1:0], y[1:0], z[1:0]};
            if (x[2] && y[2] && z[2])
                r = STD_CODE[8*(63 - int'(idx)) +: 8];
            else
                r = CHAR_X;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dna_sequence_transform_top.sv */
// A streamed result is visible on m_tvalid in the cycle after its item is accepted.
// Streaming modes take one item per cycle while the two-entry result queue has room.
// Reverse modes: s_tready drops after the last item and stays low while the buffer RAM
// drains, newest character first, one character per cycle while the queue has room.
// Reset (rst_n low, async) clears control state and mode; the buffer RAM is not cleared.
`default_nettype none

module dna_sequence_transform_top #(
    parameter int MAX_LEN = dst_pkg::MAX_LEN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dst_pkg::MODE_W-1:0]     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [dst_pkg::S_TDATA_W-1:0]  s_tdata,   // base, sub_start, sub_width
    input  wire logic                           s_tlast,
    input  wire logic [0:0]                     s_tuser,   // has_base
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [dst_pkg::CHAR_W-1:0]          m_tdata,   // out_char
    output logic                                m_tlast,
    output logic [dst_pkg::M_TUSER_W-1:0]       m_tuser    // out_has_char, overflow
);
    import dst_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [MODE_W-1:0] mode_reg;
    dst_fifo_st_t      fst;
    logic              push;
    dst_res_t          push_res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_COMP;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    dst_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_base   (s_tdata[7:0]),
        .in_has    (s_tuser[0]),
        .in_last   (s_tlast),
        .in_start  (s_tdata[23:8]),
        .in_width  (s_tdata[39:24]),
        .fst       (fst),
        .push      (push),
        .push_res  (push_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dst_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dst_ofifo u_ofifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .fst      (fst),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

/* hw/rtl/dst_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module dst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dst_ofifo.sv */
// Two-entry result queue that drives the master-side stream.
`default_nettype none

module dst_ofifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dst_pkg::dst_res_t push_res,
    output dst_pkg::dst_fifo_st_t  fst,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // out_char
    output logic                   m_tlast,
    output logic [1:0]             m_tuser    // [0] out_has_char, [1] overflow
);
    import dst_pkg::*;

    dst_res_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;
    dst_res_t   head;

    assign m_tvalid  = (count_reg != 2'd0);
    assign pop       = m_tvalid && m_tready;
    assign head      = slot_reg[rd_ptr_reg];
    assign m_tdata   = head.ch;
    assign m_tlast   = head.last;
    assign m_tuser   = {head.ovf, head.has};
    assign fst.count = count_reg;
    assign fst.pop   = pop;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dst_ctrl.sv */
// Item intake, per-mode transform, buffer writes and reverse drain sequencing.
`default_nettype none

module dst_ctrl #(
    parameter int MAX_LEN = dst_pkg::MAX_LEN_DEF,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int CW = $clog2(MAX_LEN + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [2:0]            mode,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            in_base,
    input  wire logic                  in_has,
    input  wire logic                  in_last,
    input  wire logic [15:0]           in_start,
    input  wire logic [15:0]           in_width,
    input  wire dst_pkg::dst_fifo_st_t fst,
    output logic                       push,
    output dst_pkg::dst_res_t          push_res,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [7:0]                 ram_wdata,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_raddr,
    input  wire logic [7:0]            ram_rdata
);
    import dst_pkg::*;

    typedef enum logic {S_RUN, S_DRAIN} state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CHAR_W-1:0] hold0_reg, hold0_next;
    logic [CHAR_W-1:0] hold1_reg, hold1_next;
    logic [1:0]        phase_reg, phase_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [POS_W-1:0]  width_reg, width_next;
    logic              dropped_reg, dropped_next;
    logic [AW-1:0]     daddr_reg, daddr_next;
    logic              issued_reg, issued_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              dovf_reg, dovf_next;
    logic              dcomp_reg, dcomp_next;

    logic              accept;
    logic              give;
    logic [CHAR_W-1:0] ch;
    logic [CW-1:0]     fill_upd;
    logic              dropped_upd;
    logic [POS_W-1:0]  start_eff;
    logic [POS_W-1:0]  width_eff;
    logic [POS_W-1:0]  win_lo;
    logic [POS_W:0]    win_hi;
    logic [2:0]        occ;
    logic              reverse_mode;

    assign s_tready     = (state_reg == S_RUN) && (fst.count != 2'd2);
    assign accept       = s_tvalid && s_tready;
    assign start_eff    = (pos_reg == '0) ? in_start : start_reg;
    assign width_eff    = (pos_reg == '0) ? in_width : width_reg;
    assign win_lo       = (start_eff != '0) ? start_eff - 16'd1 : '0;
    assign win_hi       = {1'b0, win_lo} + {1'b0, width_eff};
    assign reverse_mode = (mode == MODE_RCOMP) || (mode == MODE_REV);
    // queue occupancy next cycle, before any new read lands
    assign occ          = {1'b0, fst.count} + {2'b0, pend_reg} - {2'b0, fst.pop};

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        hold0_next     = hold0_reg;
        hold1_next     = hold1_reg;
        phase_next     = phase_reg;
        start_next     = start_reg;
        width_next     = width_reg;
        dropped_next   = dropped_reg;
        daddr_next     = daddr_reg;
        issued_next    = issued_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        dovf_next      = dovf_reg;
        dcomp_next     = dcomp_reg;

        give        = 1'b0;
        ch          = in_base;
        fill_upd    = fill_reg;
        dropped_upd = dropped_reg;

        push      = 1'b0;
        push_res  = '0;
        ram_we    = 1'b0;
        ram_waddr = fill_reg[AW-1:0];
        ram_wdata = in_base;
        ram_re    = 1'b0;
        ram_raddr = daddr_reg;

        if (accept)
        begin
            if (pos_reg == '0)
            begin
                start_next = in_start;
                width_next = in_width;
            end
            if (in_has)
            begin
                unique case (mode)
                    MODE_COMP:
                    begin
                        ch   = comp_char(in_base);
                        give = 1'b1;
                    end
                    MODE_RCOMP, MODE_REV:
                    begin
                        if (fill_reg < CW'(MAX_LEN))
                        begin
                            ram_we   = 1'b1;
                            fill_upd = fill_reg + CW'(1);
                        end
                        else
                        begin
                            dropped_upd = 1'b1;
                        end
                    end
                    MODE_TRANS:
                    begin
                        ch   = swap_tu(in_base);
                        give = 1'b1;
                    end
                    MODE_XLATE:
                    begin
                        if (phase_reg >= 2'd2)
                        begin
                            ch         = amino(hold0_reg, hold1_reg, in_base);
                            phase_next = 2'd0;
                            give       = 1'b1;
                        end
                        else
                        begin
                            if (phase_reg[0])
                                hold1_next = in_base;
                            else
                                hold0_next = in_base;
                            phase_next = phase_reg + 2'd1;
                        end
                    end
                    MODE_SUBSEQ:
                    begin
                        give = (pos_reg >= win_lo) && ({1'b0, pos_reg} < win_hi);
                    end
                    default:
                    begin
                        give = 1'b1;
                    end
                endcase
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + 16'd1;
                end
            end
            fill_next    = fill_upd;
            dropped_next = dropped_upd;

            if (give)
            begin
                push     = 1'b1;
                push_res = '{ch: ch, has: 1'b1, last: in_last, ovf: 1'b0};
            end

            if (in_last)
            begin
                if (reverse_mode)
                begin
                    if (fill_upd == '0)
                    begin
                        push     = 1'b1;
                        push_res = '{ch: '0, has: 1'b0, last: 1'b1, ovf: dropped_upd};
                    end
                    else
                    begin
                        state_next  = S_DRAIN;
                        daddr_next  = AW'(fill_upd - CW'(1));
                        issued_next = 1'b0;
                        dovf_next   = dropped_upd;
                        dcomp_next  = (mode == MODE_RCOMP);
                    end
                end
                else if (!give)
                begin
                    push     = 1'b1;
                    push_res = '{ch: '0, has: 1'b0, last: 1'b1, ovf: 1'b0};
                end
                // close the sequence
                pos_next     = '0;
                fill_next    = '0;
                phase_next   = 2'd0;
                dropped_next = 1'b0;
            end
        end

        if (state_reg == S_DRAIN)
        begin
            // read newest entry first; issue only when the queue can take it
            if (!issued_reg && (occ < 3'd2))
            begin
                ram_re         = 1'b1;
                pend_next      = 1'b1;
                pend_last_next = (daddr_reg == '0);
                if (daddr_reg == '0)
                    issued_next = 1'b1;
                else
                    daddr_next = daddr_reg - AW'(1);
            end
            if (pend_reg)
            begin
                push     = 1'b1;
                push_res = '{ch: dcomp_reg ? comp_char(ram_rdata) : ram_rdata,
                             has: 1'b1, last: pend_last_reg, ovf: dovf_reg};
                if (pend_last_reg)
                    state_next = S_RUN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            fill_reg      <= '0;
            pos_reg       <= '0;
            hold0_reg     <= '0;
            hold1_reg     <= '0;
            phase_reg     <= 2'd0;
            start_reg     <= '0;
            width_reg     <= '0;
            dropped_reg   <= 1'b0;
            daddr_reg     <= '0;
            issued_reg    <= 1'b1;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            dovf_reg      <= 1'b0;
            dcomp_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            hold0_reg     <= hold0_next;
            hold1_reg     <= hold1_next;
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            width_reg     <= width_next;
            dropped_reg   <= dropped_next;
            daddr_reg     <= daddr_next;
            issued_reg    <= issued_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            dovf_reg      <= dovf_next;
            dcomp_reg     <= dcomp_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dst_check.sv */
// Port-level checks for the sequence transform block, bound to the top level.
`default_nettype none

module dst_check (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [1:0] m_tuser
);

    // a stalled result keeps its valid and payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result changed");

    // a result without a character is always a closing marker with zero data
    a_bare: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 8'd0))
        else $error("bare marker malformed");

    // nothing is offered once reset has been held over a clock edge
    a_rst: assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !m_tvalid)
        else $error("result offered in reset");

    // handshake lines stay known out of reset
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_tvalid, s_tready, m_tvalid}))
        else $error("handshake line unknown");

endmodule

bind dna_sequence_transform_top dst_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/sv/dna_sequence_transform_top_test.sv */
`timescale 1ns / 100ps
// Self-checking stream testbench for the DNA sequence transform block.
module dna_sequence_transform_top_test;

    import dst_pkg::MODE_COMP;
    import dst_pkg::MODE_RCOMP;
    import dst_pkg::MODE_REV;
    import dst_pkg::MODE_TRANS;
    import dst_pkg::MODE_XLATE;
    import dst_pkg::MODE_SUBSEQ;

    localparam int BUF_DEPTH     = dst_pkg::MAX_LEN_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 50;

    // modes outside the defined set pass characters through
    localparam logic [2:0] MODE_PASS_A = 3'd6;
    localparam logic [2:0] MODE_PASS_B = 3'd7;

    localparam logic [8*64-1:0] AMINO_TABLE =
        "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";
    localparam logic [8*5-1:0]  NUCLEOTIDES = "ACGTU";
    localparam logic [8*11-1:0] IUPAC_OTHER = "RYKMBVDHNSW";

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
        logic       ovf;
    } seq_char_t;

    typedef struct packed {
        logic        cfg;
        logic [2:0]  mode;
        logic [7:0]  base;
        logic        has;
        logic        last;
        logic [15:0] start;
        logic [15:0] width;
        logic        typed;
        seq_char_t   want;
    } seq_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // base, sub_start, sub_width
    logic        s_tlast = 1'b0;
    logic [0:0]  s_tuser = '0;     // has_base
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // out_char
    logic        m_tlast;
    logic [1:0]  m_tuser;          // out_has_char, overflow

    // predicted block state
    logic [2:0]  mode_reg = MODE_COMP;
    logic [7:0]  rev_buf [0:63];
    int          fill_cnt = 0;
    logic [15:0] seq_pos = '0;
    logic [7:0]  codon_part [0:1];
    logic [1:0]  codon_phase = '0;
    logic [15:0] win_start = '0;
    logic [15:0] win_width = '0;
    logic        chars_dropped = 1'b0;

    seq_char_t   step_chars [$];
    seq_char_t   expected_chars [$];
    seq_row_t    directed_rows [$];

    int mismatches = 0;
    int seq_items = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    dna_sequence_transform_top #(.MAX_LEN(BUF_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] iupac_complement(input logic [7:0] b);
        case (b)
            "A": return "T";  "a": return "t";
            "T": return "A";  "t": return "a";
            "U": return "A";  "u": return "a";
            "G": return "C";  "g": return "c";
            "C": return "G";  "c": return "g";
            "R": return "Y";  "r": return "y";
            "Y": return "R";  "y": return "r";
            "K": return "M";  "k": return "m";
            "M": return "K";  "m": return "k";
            "B": return "V";  "b": return "v";
            "V": return "B";  "v": return "b";
            "D": return "H";  "d": return "h";
            "H": return "D";  "h": return "d";
            default: return b;
        endcase
    endfunction

    function automatic logic [7:0] swap_t_u(input logic [7:0] b);
        case (b)
            "T": return "U";  "t": return "u";
            "U": return "T";  "u": return "t";
            default: return b;
        endcase
    endfunction

    // two-bit nucleotide code, -1 for anything else
    function automatic int base_code(input logic [7:0] b);
        case (b)
            "A", "a": return 0;
            "C", "c": return 1;
            "G", "g": return 2;
            "T", "t", "U", "u": return 3;
            default: return -1;
        endcase
    endfunction

    function automatic logic [7:0] codon_to_amino(input logic [7:0] a, input logic [7:0] b,
                                                  input logic [7:0] c);
        int x;
        int y;
        int z;
        x = base_code(a);
        y = base_code(b);
        z = base_code(c);
        if (x < 0 || y < 0 || z < 0)
            return "X";
        return AMINO_TABLE[8*(63 - (x*16 + y*4 + z)) +: 8];
    endfunction

    function automatic seq_char_t seq_out(input logic [7:0] ch, input logic has,
                                          input logic last, input logic ovf);
        seq_char_t r;
        r.ch = has ? ch : 8'h00;
        r.has = has;
        r.last = last;
        r.ovf = ovf;
        return r;
    endfunction

    function automatic seq_row_t item_row(input logic [7:0] b, input logic has,
                                          input logic last, input logic [15:0] st,
                                          input logic [15:0] w);
        seq_row_t r;
        r = '0;
        r.base = b;
        r.has = has;
        r.last = last;
        r.start = st;
        r.width = w;
        return r;
    endfunction

    function automatic seq_row_t typed_row(input logic [7:0] b, input logic has,
                                           input logic last, input logic [15:0] st,
                                           input logic [15:0] w, input seq_char_t want);
        seq_row_t r;
        r = item_row(b, has, last, st, w);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic seq_row_t mode_row(input logic [2:0] m);
        seq_row_t r;
        r = '0;
        r.cfg = 1'b1;
        r.mode = m;
        return r;
    endfunction

    function automatic logic [7:0] pick_base();
        logic [7:0] b;
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            b = NUCLEOTIDES[8*$urandom_range(0, 4) +: 8];
        else if (r == 8)
            b = IUPAC_OTHER[8*$urandom_range(0, 10) +: 8];
        else
            return 8'($urandom);
        if ($urandom_range(0, 1) == 1)
            b = b | 8'h20;
        return b;
    endfunction

    function automatic logic [2:0] pick_mode();
        int r;
        r = $urandom_range(0, 13);
        if (r == 12)
            return MODE_PASS_A;
        if (r == 13)
            return MODE_PASS_B;
        case (r % 6)
            0: return MODE_COMP;
            1: return MODE_RCOMP;
            2: return MODE_REV;
            3: return MODE_TRANS;
            4: return MODE_XLATE;
            default: return MODE_SUBSEQ;
        endcase
    endfunction

    // Work out the results one accepted item causes and advance the predicted state.
    task automatic transform_item(input logic [7:0] b, input logic has, input logic last,
                                  input logic [15:0] st, input logic [15:0] w);
        logic [7:0]  ch;
        logic        give;
        logic        emitted;
        logic [16:0] lo;
        logic [16:0] hi;
        int          k;
        step_chars.delete();
        ch = 8'h00;
        give = 1'b0;
        emitted = 1'b0;
        if (seq_pos == 16'd0)
        begin
            win_start = st;
            win_width = w;
        end
        if (has)
        begin
            case (mode_reg)
                MODE_COMP:
                begin
                    ch = iupac_complement(b);
                    give = 1'b1;
                end
                MODE_RCOMP, MODE_REV:
                begin
                    if (fill_cnt < BUF_DEPTH)
                    begin
                        rev_buf[6'(fill_cnt)] = b;
                        fill_cnt++;
                    end
                    else
                        chars_dropped = 1'b1;
                end
                MODE_TRANS:
                begin
                    ch = swap_t_u(b);
                    give = 1'b1;
                end
                MODE_XLATE:
                begin
                    if (codon_phase >= 2'd2)
                    begin
                        ch = codon_to_amino(codon_part[0], codon_part[1], b);
                        codon_phase = 2'd0;
                        give = 1'b1;
                    end
                    else
                    begin
                        codon_part[codon_phase[0]] = b;
                        codon_phase++;
                    end
                end
                MODE_SUBSEQ:
                begin
                    lo = (win_start != 16'd0) ? {1'b0, win_start} - 17'd1 : 17'd0;
                    hi = lo + {1'b0, win_width};
                    if ({1'b0, seq_pos} >= lo && {1'b0, seq_pos} < hi)
                    begin
                        ch = b;
                        give = 1'b1;
                    end
                end
                default:
                begin
                    ch = b;
                    give = 1'b1;
                end
            endcase
            if (seq_pos != 16'hFFFF)
                seq_pos++;
            if (give)
            begin
                step_chars.push_back(seq_out(ch, 1'b1, last, 1'b0));
                emitted = 1'b1;
            end
        end
        if (last)
        begin
            if (mode_reg == MODE_RCOMP || mode_reg == MODE_REV)
            begin
                for (k = fill_cnt - 1; k >= 0; k--)
                begin
                    ch = (mode_reg == MODE_RCOMP) ? iupac_complement(rev_buf[6'(k)])
                                                  : rev_buf[6'(k)];
                    step_chars.push_back(seq_out(ch, 1'b1, k == 0, chars_dropped));
                end
                if (fill_cnt == 0)
                    step_chars.push_back(seq_out(8'h00, 1'b0, 1'b1, chars_dropped));
            end
            else if (!emitted)
                step_chars.push_back(seq_out(8'h00, 1'b0, 1'b1, 1'b0));
            seq_pos = 16'd0;
            fill_cnt = 0;
            codon_phase = 2'd0;
            chars_dropped = 1'b0;
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic has, input logic last,
                             input logic [15:0] st, input logic [15:0] w,
                             input logic typed, input seq_char_t want);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {w, st, b};
        s_tlast <= last;
        s_tuser <= has;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        transform_item(b, has, last, st, w);
        if (typed)
            expected_chars.push_back(want);
        else
            foreach (step_chars[i])
                expected_chars.push_back(step_chars[i]);
        if (has || last)
            seq_items++;
    endtask

    // Drop valid, wait for every expected item, then let the pipeline go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_mode(input logic [2:0] m);
        settle();
        cfg_wdata <= m;
        cfg_we <= 1'b1;
        @(posedge clk);
        mode_reg = m;
        cfg_we <= 1'b0;
    endtask

    task automatic send_sequence(input int len, input logic break_mode);
        int          split;
        int          k;
        logic [15:0] st;
        logic [15:0] w;
        split = break_mode ? $urandom_range(1, len - 1) : -1;
        if ($urandom_range(0, 3) != 0)
        begin
            st = 16'($urandom_range(0, len + 2));
            w = 16'($urandom_range(0, len + 2));
        end
        else
        begin
            st = 16'($urandom);
            w = 16'($urandom);
        end
        if (len == 0)
        begin
            send_item(8'($urandom), 1'b0, 1'b1, st, w, 1'b0, '0);
            return;
        end
        for (k = 0; k < len; k++)
        begin
            if (k == split)
                set_mode(pick_mode());
            // stray item without a character
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, k == 0 ? st : 16'($urandom),
                          k == 0 ? w : 16'($urandom), 1'b0, '0);
            send_item(pick_base(), 1'b1, k == len - 1, k == 0 ? st : 16'($urandom),
                      k == 0 ? w : 16'($urandom), 1'b0, '0);
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        seq_char_t oldest;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("out_char: expected nothing, got %0h", m_tdata);
                mismatches++;
            end
            else
            begin
                oldest = expected_chars.pop_front();
                compare_field("out_char", 32'(oldest.ch), 32'(m_tdata));
                compare_field("out_has_char", 32'(oldest.has), 32'(m_tuser[0]));
                compare_field("out_last", 32'(oldest.last), 32'(m_tlast));
                compare_field("overflow", 32'(oldest.ovf), 32'(m_tuser[1]));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int          p;
        int          r;
        int          len;
        int          phase_start;
        logic [2:0]  m;
        int          idle_by_phase [0:3];
        int          stall_by_phase [0:3];

        idle_by_phase = '{0, 66, 0, 24};
        stall_by_phase = '{0, 0, 66, 24};

        // mode is left at its reset value for the first rows
        directed_rows.push_back(typed_row("A", 1'b1, 1'b1, 16'd0, 16'd0,
                                          seq_out("T", 1'b1, 1'b1, 1'b0)));
        directed_rows.push_back(typed_row("h", 1'b1, 1'b0, 16'd0, 16'd0,
                                          seq_out("d", 1'b1, 1'b0, 1'b0)));
        directed_rows.push_back(typed_row(8'hFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF,
                                          seq_out(8'hFF, 1'b1, 1'b1, 1'b0)));
        directed_rows.push_back(typed_row(8'h00, 1'b0, 1'b1, 16'd0, 16'd0,
                                          seq_out(8'h00, 1'b0, 1'b1, 1'b0)));
        directed_rows.push_back(item_row(8'hFF, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(mode_row(MODE_SUBSEQ));
        directed_rows.push_back(item_row("A", 1'b1, 1'b0, 16'd2, 16'd1));
        directed_rows.push_back(item_row("C", 1'b1, 1'b0, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(typed_row("T", 1'b1, 1'b1, 16'd0, 16'd0,
                                          seq_out(8'h00, 1'b0, 1'b1, 1'b0)));
        directed_rows.push_back(typed_row("A", 1'b1, 1'b1, 16'd0, 16'd0,
                                          seq_out(8'h00, 1'b0, 1'b1, 1'b0)));
        directed_rows.push_back(typed_row("G", 1'b1, 1'b1, 16'hFFFF, 16'hFFFF,
                                          seq_out(8'h00, 1'b0, 1'b1, 1'b0)));
        directed_rows.push_back(typed_row("c", 1'b1, 1'b1, 16'd0, 16'hFFFF,
                                          seq_out("c", 1'b1, 1'b1, 1'b0)));
        directed_rows.push_back(mode_row(MODE_XLATE));
        directed_rows.push_back(item_row("T", 1'b1, 1'b0, 16'd0, 16'd0));
        directed_rows.push_back(item_row("a", 1'b1, 1'b0, 16'd0, 16'd0));
        directed_rows.push_back(typed_row("A", 1'b1, 1'b0, 16'd0, 16'd0,
                                          seq_out("*", 1'b1, 1'b0, 1'b0)));
        directed_rows.push_back(item_row("N", 1'b1, 1'b0, 16'd0, 16'd0));
        directed_rows.push_back(item_row("c", 1'b1, 1'b0, 16'd0, 16'd0));
        directed_rows.push_back(typed_row("g", 1'b1, 1'b0, 16'd0, 16'd0,
                                          seq_out("X", 1'b1, 1'b0, 1'b0)));
        directed_rows.push_back(typed_row("A", 1'b1, 1'b1, 16'd0, 16'd0,
                                          seq_out(8'h00, 1'b0, 1'b1, 1'b0)));
        // switch from translate to transcribe in the middle of a sequence
        directed_rows.push_back(item_row("A", 1'b1, 1'b0, 16'd0, 16'd0));
        directed_rows.push_back(item_row("T", 1'b1, 1'b0, 16'd0, 16'd0));
        directed_rows.push_back(mode_row(MODE_TRANS));
        directed_rows.push_back(typed_row("G", 1'b1, 1'b1, 16'd0, 16'd0,
                                          seq_out("G", 1'b1, 1'b1, 1'b0)));
        directed_rows.push_back(mode_row(MODE_RCOMP));
        directed_rows.push_back(item_row("A", 1'b1, 1'b0, 16'd0, 16'd0));
        directed_rows.push_back(item_row("c", 1'b1, 1'b0, 16'd0, 16'd0));
        directed_rows.push_back(item_row("N", 1'b1, 1'b1, 16'd0, 16'd0));
        directed_rows.push_back(mode_row(MODE_REV));
        directed_rows.push_back(typed_row(8'h00, 1'b0, 1'b1, 16'd0, 16'd0,
                                          seq_out(8'h00, 1'b0, 1'b1, 1'b0)));
        directed_rows.push_back(mode_row(MODE_TRANS));
        directed_rows.push_back(item_row("T", 1'b1, 1'b0, 16'd0, 16'd0));
        directed_rows.push_back(item_row("u", 1'b1, 1'b1, 16'd0, 16'd0));
        directed_rows.push_back(mode_row(MODE_PASS_A));
        directed_rows.push_back(typed_row("A", 1'b1, 1'b1, 16'd0, 16'd0,
                                          seq_out("A", 1'b1, 1'b1, 1'b0)));
        directed_rows.push_back(mode_row(MODE_PASS_B));
        directed_rows.push_back(typed_row(8'h80, 1'b1, 1'b1, 16'd0, 16'd0,
                                          seq_out(8'h80, 1'b1, 1'b1, 1'b0)));

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg)
                set_mode(directed_rows[i].mode);
            else
                send_item(directed_rows[i].base, directed_rows[i].has, directed_rows[i].last,
                          directed_rows[i].start, directed_rows[i].width,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        for (p = 0; p < 4; p++)
        begin
            settle();
            sender_idle_pct = idle_by_phase[p];
            recv_stall_pct <= stall_by_phase[p];
            phase_start = seq_items;
            if (p == 0)
            begin
                // fill the block while the receiver holds off
                set_mode(MODE_COMP);
                hold_asked <= hold_asked + 1;
                send_sequence(40, 1'b0);
            end
            if (p == 1 || p == 3)
            begin
                set_mode(p == 1 ? MODE_RCOMP : MODE_REV);
                send_sequence($urandom_range(65, 70), 1'b0);
            end
            while (seq_items - phase_start < PHASE_ITEMS)
            begin
                m = pick_mode();
                if (m != mode_reg)
                    set_mode(m);
                r = $urandom_range(0, 19);
                if (r == 0)
                    len = 0;
                else if (r == 1)
                    len = $urandom_range(62, 70);
                else
                    len = $urandom_range(1, 12);
                send_sequence(len, len >= 2 && $urandom_range(0, 9) == 0);
            end
        end

        settle();
        repeat (12)
            @(posedge clk);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dst_pkg.sv
hw/rtl/dst_ram.sv
hw/rtl/dst_ofifo.sv
hw/rtl/dst_ctrl.sv
hw/rtl/dna_sequence_transform_top.sv
hw/rtl/dst_check.sv
tb/sv/dna_sequence_transform_top_test.sv
